/* hw/rtl/usbt_pkg.sv */
// Shared types, constants and stencil weight table for the upsample-by-two
// stencil interpolator. No dependencies.
package usbt_pkg;

    // window and stencil geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int NUM_TAPS     = 8;
    localparam int TAP_IDX_W    = 3;
    localparam int NUM_MODES    = 16;
    localparam int MODE_W       = 4;

    // weights are numerators over 2**WEIGHT_SHIFT
    localparam int WEIGHT_W     = 13;
    localparam int WEIGHT_SHIFT = 11;

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_IDX_STENCIL_MODE = 1'b0;

    // one phase request from the issue logic to the datapath
    typedef struct packed {
        logic              vld;
        logic              phase;
        logic [MODE_W-1:0] mode;
    } t_iss_req;

    typedef logic signed [WEIGHT_W-1:0] t_weight;

    // [mode][phase][tap], tap j has offset j-3 from the center
    // modes 14 and 15 are unused and carry all-zero weights
    localparam t_weight WEIGHTS [NUM_MODES][2][NUM_TAPS] = '{
        // vertex poly 1
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 1024, 1024, 0, 0, 0}},
        // vertex poly 3
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, -128, 1152, 1152, -128, 0, 0}},
        // vertex poly 5
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 24, -200, 1200, 1200, -200, 24, 0}},
        // vertex poly 7
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{-5, 49, -245, 1225, 1225, -245, 49, -5}},
        // cell poly 0
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 2048, 0, 0, 0, 0}},
        // cell poly 1
        '{'{0, 0, 512, 1536, 0, 0, 0, 0}, '{0, 0, 0, 1536, 512, 0, 0, 0}},
        // cell poly 2
        '{'{0, 0, 320, 1920, -192, 0, 0, 0}, '{0, 0, -192, 1920, 320, 0, 0, 0}},
        // cell poly 3
        '{'{0, -80, 560, 1680, -112, 0, 0, 0}, '{0, 0, -112, 1680, 560, -80, 0, 0}},
        // cell poly 4
        '{'{0, -45, 420, 1890, -252, 35, 0, 0}, '{0, 35, -252, 1890, 420, -45, 0, 0}},
        // vertex cons 0: no taps between points
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}},
        // vertex cons 1: between-point value averages center and the point before
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 1024, 1024, 0, 0, 0, 0}},
        // cell cons 0
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 2048, 0, 0, 0, 0}},
        // cell cons 2
        '{'{0, 0, 256, 2048, -256, 0, 0, 0}, '{0, 0, -256, 2048, 256, 0, 0, 0}},
        // cell cons 4
        '{'{0, -48, 352, 2048, -352, 48, 0, 0}, '{0, 48, -352, 2048, 352, -48, 0, 0}},
        // unused
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}}
    };

    function automatic t_weight tap_weight(
        input logic [MODE_W-1:0]    mode,
        input logic                 phase,
        input logic [TAP_IDX_W-1:0] tap
    );
        return WEIGHTS[mode][phase][tap];
    endfunction

endpackage

/* hw/rtl/upsample_by_two_stencil_interp.sv */
// Top level of the upsample-by-two stencil interpolator: sample window,
// phase issue, register port. Depends on usbt_pkg and usbt_stencil_pipe.
//
// Usage:
//   Input channel: one coarse sample per beat on i_coarse_sample, handshake
//   i_coarse_valid / o_coarse_stall. Output channel: two beats per input,
//   o_fine_phase 0 then 1, handshake o_fine_valid / i_fine_stall.
//   stencil_mode is written through the APB port at byte address 0 while
//   the block is idle; modes 14 and 15 give zero results.
// Path: a sample accepted into the window issues its phase-0 request, which
//   passes the product, sum and output registers; its phase-1 result follows.
// Throughput: the single product/adder datapath produces one fine sample per
//   cycle while the output is not stalled, and each input needs two; a new
//   input is taken in the same cycle the previous one's phase 1 is issued,
//   so up to five results may be owed behind a stalled output: three in
//   the datapath and two for the held window.
// Reset: clears the window to zero, stencil_mode to 0, and all valid bits.
// Stall: a stalled output beat holds; the datapath fills its free stages
//   and then o_coarse_stall rises until the output drains.
module upsample_by_two_stencil_interp
    import usbt_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // coarse input
    input  logic                          i_coarse_valid,
    output logic                          o_coarse_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_coarse_sample,
    // fine output
    output logic                          o_fine_valid,
    input  logic                          i_fine_stall,
    output logic signed [SAMPLE_BITS-1:0] o_fine_sample,
    output logic                          o_fine_phase,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    logic [MODE_W-1:0]             r_mode;
    logic signed [SAMPLE_BITS-1:0] r_win [WINDOW_DEPTH];
    logic                          r_win_busy;
    logic                          r_iss_phase;

    logic     pipe_rdy;
    logic     issue, done, accept;
    t_iss_req req;

    // register port: write on the access cycle, reads are combinational
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_STENCIL_MODE)
                    ? {{(DATA_W - MODE_W){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_IDX_STENCIL_MODE) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    // issue both phases of the current window, take the next beat with phase 1
    assign issue          = r_win_busy && pipe_rdy;
    assign done           = issue && r_iss_phase;
    assign o_coarse_stall = r_win_busy && !done;
    assign accept         = i_coarse_valid && !o_coarse_stall;

    assign req.vld   = issue;
    assign req.phase = r_iss_phase;
    assign req.mode  = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_busy  <= 1'b0;
            r_iss_phase <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_win[0] <= i_coarse_sample;
                for (int i = 1; i < WINDOW_DEPTH; i++) begin
                    r_win[i] <= r_win[i-1];
                end
                r_win_busy  <= 1'b1;
                r_iss_phase <= 1'b0;
            end else if (done) begin
                r_win_busy <= 1'b0;
            end else if (issue) begin
                r_iss_phase <= 1'b1;
            end
        end
    end

    usbt_stencil_pipe #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_win    (r_win),
        .o_rdy    (pipe_rdy),
        .i_stall  (i_fine_stall),
        .o_valid  (o_fine_valid),
        .o_sample (o_fine_sample),
        .o_phase  (o_fine_phase)
    );

    // a fresh beat always starts at phase 0
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_win_busy && !r_iss_phase)
        else $error("accepted beat did not start at phase 0");
    // the window is freed after phase 1 unless a new beat came in
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && !accept |=> !r_win_busy)
        else $error("window still busy after phase 1 issue");
    // phase 1 is only issued for a window that was already busy
    a_phase1_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue && r_iss_phase |-> $past(r_win_busy))
        else $error("phase 1 issued without a pending window");

endmodule

/* hw/rtl/usbt_stencil_pipe.sv */
// Three-stage stencil datapath: tap products, partial sums, round and saturate.
// Depends on usbt_pkg for the weight table and the request struct.
module usbt_stencil_pipe
    import usbt_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_iss_req                      i_req,
    input  logic signed [SAMPLE_BITS-1:0] i_win [WINDOW_DEPTH],
    output logic                          o_rdy,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_phase
);

    localparam int ACC_W = SAMPLE_BITS + WEIGHT_W;
    localparam int Q_W   = ACC_W - WEIGHT_SHIFT;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (WEIGHT_SHIFT - 1);
    localparam logic signed [Q_W-1:0] SAT_HI =
        {{(Q_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_LO =
        {{(Q_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    // stage registers
    logic                    r_p_vld, r_a_vld, r_o_vld;
    logic                    r_p_phase, r_a_phase, r_o_phase;
    logic signed [ACC_W-1:0] r_prod [NUM_TAPS];
    logic signed [ACC_W-1:0] r_qa, r_qb;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;

    logic signed [ACC_W-1:0] n_prod [NUM_TAPS];
    logic signed [ACC_W-1:0] n_qa, n_qb;
    logic signed [ACC_W-1:0] tot;
    logic signed [Q_W-1:0]   quo;
    logic signed [SAMPLE_BITS-1:0] n_o_sample;
    logic o_adv, a_rdy, p_rdy;

    // advance each stage when the one after it has room
    assign o_adv = !r_o_vld || !i_stall;
    assign a_rdy = !r_a_vld || o_adv;
    assign p_rdy = !r_p_vld || a_rdy;
    assign o_rdy = p_rdy;

    // tap products, tap j reads the window entry j places from the oldest
    always_comb begin
        for (int j = 0; j < NUM_TAPS; j++) begin
            n_prod[j] = ACC_W'(tap_weight(i_req.mode, i_req.phase, TAP_IDX_W'(j)))
                        * ACC_W'(i_win[NUM_TAPS - 1 - j]);
        end
    end

    // two partial sums of four taps each
    always_comb begin
        n_qa = r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
        n_qb = r_prod[4] + r_prod[5] + r_prod[6] + r_prod[7];
    end

    // round half up by floor of biased sum, then clamp to the sample range
    always_comb begin
        tot = r_qa + r_qb + ROUND_BIAS;
        quo = tot[ACC_W-1:WEIGHT_SHIFT];
        if (quo > SAT_HI) begin
            n_o_sample = SAT_HI[SAMPLE_BITS-1:0];
        end else if (quo < SAT_LO) begin
            n_o_sample = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            n_o_sample = quo[SAMPLE_BITS-1:0];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (p_rdy) begin
                r_p_vld <= i_req.vld;
            end
            if (a_rdy) begin
                r_a_vld <= r_p_vld;
            end
            if (o_adv) begin
                r_o_vld <= r_a_vld;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (p_rdy && i_req.vld) begin
            r_prod    <= n_prod;
            r_p_phase <= i_req.phase;
        end
        if (a_rdy && r_p_vld) begin
            r_qa      <= n_qa;
            r_qb      <= n_qb;
            r_a_phase <= r_p_phase;
        end
        if (o_adv && r_a_vld) begin
            r_o_sample <= n_o_sample;
            r_o_phase  <= r_a_phase;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_sample = r_o_sample;
    assign o_phase  = r_o_phase;

    // neighboring beats in flight always belong to opposite phases
    a_phase_alt_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld && r_a_vld |-> r_p_phase != r_a_phase)
        else $error("stage P and A hold the same phase");
    a_phase_alt_ao: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && r_o_vld |-> r_a_phase != r_o_phase)
        else $error("stage A and output hold the same phase");
    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && i_stall |=> r_o_vld && $stable(r_o_sample) && $stable(r_o_phase))
        else $error("stalled output beat changed");

endmodule

/* dv/usbt_fine_checker.sv */
// Checker for the upsample-by-two stencil interpolator: watches the coarse,
// fine and register channels, predicts every fine beat and compares.
// Depends on usbt_pkg for widths and the register index.
module usbt_fine_checker
    import usbt_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_coarse_valid,
    input  logic                   i_coarse_stall,
    input  logic [SAMPLE_BITS-1:0] i_coarse_sample,
    input  logic                   i_fine_valid,
    input  logic                   i_fine_stall,
    input  logic [SAMPLE_BITS-1:0] i_fine_sample,
    input  logic                   i_fine_phase,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [ADDR_W-1:0]      i_paddr,
    input  logic [DATA_W-1:0]      i_pwdata,
    output int                     o_pending_beats,
    output int                     o_error_count
);

    localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * int'(REG_IDX_STENCIL_MODE));
    localparam int     NUM_STENCILS = 14;
    localparam longint SAT_HI       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO       = -SAT_HI - 1;
    localparam int     MAX_PRINTS   = 40;

    // tap numerators over 2**WEIGHT_SHIFT, [stencil][phase][offset+3]
    localparam int STENCIL_NUMER [NUM_STENCILS][2][NUM_TAPS] = '{
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 1024, 1024, 0, 0, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, -128, 1152, 1152, -128, 0, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 24, -200, 1200, 1200, -200, 24, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{-5, 49, -245, 1225, 1225, -245, 49, -5}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 2048, 0, 0, 0, 0}},
        '{'{0, 0, 512, 1536, 0, 0, 0, 0}, '{0, 0, 0, 1536, 512, 0, 0, 0}},
        '{'{0, 0, 320, 1920, -192, 0, 0, 0}, '{0, 0, -192, 1920, 320, 0, 0, 0}},
        '{'{0, -80, 560, 1680, -112, 0, 0, 0}, '{0, 0, -112, 1680, 560, -80, 0, 0}},
        '{'{0, -45, 420, 1890, -252, 35, 0, 0}, '{0, 35, -252, 1890, 420, -45, 0, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 1024, 1024, 0, 0, 0, 0}},
        '{'{0, 0, 0, 2048, 0, 0, 0, 0}, '{0, 0, 0, 2048, 0, 0, 0, 0}},
        '{'{0, 0, 256, 2048, -256, 0, 0, 0}, '{0, 0, -256, 2048, 256, 0, 0, 0}},
        '{'{0, -48, 352, 2048, -352, 48, 0, 0}, '{0, 48, -352, 2048, 352, -48, 0, 0}}
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          phase;
    } fine_beat_t;

    logic signed [SAMPLE_BITS-1:0] coarse_window [WINDOW_DEPTH];
    logic [MODE_W-1:0]             active_mode;
    fine_beat_t                    expected_fine [$];
    fine_beat_t                    oldest_fine;
    int                            mismatch_count = 0;

    assign o_error_count = mismatch_count;

    // weighted sum over the window, round half up, clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] interp_fine(
        input logic [MODE_W-1:0] mode,
        input logic              phase
    );
        longint acc = 0;
        longint q;
        if (mode >= NUM_STENCILS) begin
            return '0;
        end
        for (int j = 0; j < NUM_TAPS; j++) begin
            acc += longint'(STENCIL_NUMER[mode][phase][j])
                   * longint'(coarse_window[NUM_TAPS - 1 - j]);
        end
        q = (acc + (longint'(1) << (WEIGHT_SHIFT - 1))) >>> WEIGHT_SHIFT;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end
        if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t checker: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (coarse_window[k]) coarse_window[k] = '0;
            active_mode = '0;
            expected_fine.delete();
        end else begin
            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MODE_ADDR) begin
                active_mode = i_pwdata[MODE_W-1:0];
            end
            // compare an outgoing beat with the oldest prediction
            if (i_fine_valid && !i_fine_stall) begin
                if (expected_fine.size() == 0) begin
                    report_mismatch($sformatf("unexpected fine beat sample=%h phase=%b",
                                              i_fine_sample, i_fine_phase));
                end else begin
                    oldest_fine = expected_fine.pop_front();
                    if (i_fine_sample !== oldest_fine.sample) begin
                        report_mismatch($sformatf("fine_sample got %h want %h (phase %b)",
                                                  i_fine_sample, oldest_fine.sample,
                                                  oldest_fine.phase));
                    end
                    if (i_fine_phase !== oldest_fine.phase) begin
                        report_mismatch($sformatf("fine_phase got %b want %b",
                                                  i_fine_phase, oldest_fine.phase));
                    end
                end
            end
            // shift in an accepted coarse beat and predict its pair
            if (i_coarse_valid && !i_coarse_stall) begin
                for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
                    coarse_window[k] = coarse_window[k-1];
                end
                coarse_window[0] = i_coarse_sample;
                expected_fine.push_back('{interp_fine(active_mode, 1'b0), 1'b0});
                expected_fine.push_back('{interp_fine(active_mode, 1'b1), 1'b1});
            end
        end
        o_pending_beats <= expected_fine.size();
    end

endmodule

/* dv/upsample_by_two_stencil_interp_test.sv */
// Testbench top for the upsample-by-two stencil interpolator: drives coarse
// beats, register writes and output stalls. Depends on usbt_pkg, the block
// and usbt_fine_checker.
module upsample_by_two_stencil_interp_test;
    import usbt_pkg::*;

    localparam int SAMPLE_BITS   = 32;
    localparam int CLK_PERIOD    = 10;
    localparam int RUN_LIMIT     = 600000 * CLK_PERIOD;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_SAMPLES = 150;
    localparam logic [ADDR_W-1:0] MODE_ADDR = ADDR_W'(4 * int'(REG_IDX_STENCIL_MODE));
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        VERTEX_POLY1, VERTEX_POLY3, VERTEX_POLY5, VERTEX_POLY7,
        CELL_POLY0, CELL_POLY1, CELL_POLY2, CELL_POLY3, CELL_POLY4,
        VERTEX_CONS0, VERTEX_CONS1,
        CELL_CONS0, CELL_CONS2, CELL_CONS4,
        MODE_UNUSED14, MODE_UNUSED15
    } t_stencil_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_coarse_valid;
    logic                          o_coarse_stall;
    logic signed [SAMPLE_BITS-1:0] i_coarse_sample;
    logic                          o_fine_valid;
    logic                          i_fine_stall;
    logic signed [SAMPLE_BITS-1:0] o_fine_sample;
    logic                          o_fine_phase;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_W-1:0]             paddr;
    logic [DATA_W-1:0]             pwdata;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;
    int                            pending_beats;
    int                            error_count;
    int                            gap_chance   = 0;
    int                            stall_chance = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    upsample_by_two_stencil_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_coarse_valid  (i_coarse_valid),
        .o_coarse_stall  (o_coarse_stall),
        .i_coarse_sample (i_coarse_sample),
        .o_fine_valid    (o_fine_valid),
        .i_fine_stall    (i_fine_stall),
        .o_fine_sample   (o_fine_sample),
        .o_fine_phase    (o_fine_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    usbt_fine_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_coarse_valid  (i_coarse_valid),
        .i_coarse_stall  (o_coarse_stall),
        .i_coarse_sample (i_coarse_sample),
        .i_fine_valid    (o_fine_valid),
        .i_fine_stall    (i_fine_stall),
        .i_fine_sample   (o_fine_sample),
        .i_fine_phase    (o_fine_phase),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_pending_beats (pending_beats),
        .o_error_count   (error_count)
    );

    // present one coarse beat and hold it until accepted
    task automatic push_coarse(input logic signed [SAMPLE_BITS-1:0] value);
        if (gap_chance != 0 && $urandom_range(0, 15) < gap_chance) begin
            i_coarse_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_coarse_valid  <= 1'b1;
        i_coarse_sample <= value;
        @(posedge i_clk);
        while (o_coarse_stall) @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted fine beat has left
    task automatic wait_fine_drained();
        i_coarse_valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
    endtask

    // setup cycle, then access cycle until pready
    task automatic write_stencil_mode(input t_stencil_mode mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {DATA_W'($urandom()) >> MODE_W << MODE_W} | DATA_W'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mix of full-range, small, and extreme coarse values
    function automatic logic signed [SAMPLE_BITS-1:0] pick_coarse();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return {{14{r[17]}}, r[17:0]};
            4:       return r[0] ? SAMPLE_MAX - r[3:0] : SAMPLE_MIN + r[3:0];
            default: return r;
        endcase
    endfunction

    // random stall bursts on the fine side
    initial begin
        i_fine_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_chance != 0 && $urandom_range(0, 15) < stall_chance) begin
                i_fine_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_fine_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_stencil_mode mode;
        bit            last_phase;
        i_rst_n         <= 1'b0;
        i_coarse_valid  <= 1'b0;
        i_coarse_sample <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start-up in the reset mode: zero entries still in the window
        push_coarse(SAMPLE_MAX);
        push_coarse(SAMPLE_MIN);
        push_coarse(1);
        push_coarse(-1);

        // widest stencil with alternating extremes to hit both clamps
        wait_fine_drained();
        write_stencil_mode(VERTEX_POLY7);
        repeat (2) begin
            push_coarse(SAMPLE_MAX);
            push_coarse(SAMPLE_MAX);
            push_coarse(SAMPLE_MIN);
            push_coarse(SAMPLE_MIN);
        end

        // one beat in every mode, unused ones included
        for (int m = 0; m < NUM_MODES; m++) begin
            wait_fine_drained();
            write_stencil_mode(t_stencil_mode'(m));
            push_coarse({4'(m), 12'hA5C, 16'h8000});
        end

        // random phases, each with its own mode and idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            last_phase = (ph == NUM_PHASES - 1);
            wait_fine_drained();
            case (ph)
                0:       mode = VERTEX_POLY1;
                1:       mode = MODE_UNUSED15;
                2:       mode = CELL_CONS4;
                3:       mode = VERTEX_CONS1;
                default: mode = t_stencil_mode'($urandom_range(0, NUM_MODES - 1));
            endcase
            write_stencil_mode(mode);
            gap_chance   = last_phase ? 0 : $urandom_range(0, 8);
            stall_chance = last_phase ? 0 : $urandom_range(0, 8);
            for (int i = 0; i < PHASE_SAMPLES; i++) begin
                if (!last_phase && $urandom_range(0, 199) == 0) begin
                    wait_fine_drained();
                end
                push_coarse(pick_coarse());
            end
        end

        wait_fine_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/usbt_pkg.sv
hw/rtl/usbt_stencil_pipe.sv
hw/rtl/upsample_by_two_stencil_interp.sv
dv/usbt_fine_checker.sv
dv/upsample_by_two_stencil_interp_test.sv
